/* rtl/bshl_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded sorted hit list package
// Shared field widths, input kinds, controller states and the cell command.
// ----------------------------------------------------------------------------
package bshl_pkg;

    localparam int unsigned KEY_W  = 17;
    localparam int unsigned USER_W = 16;
    localparam int unsigned CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DRAIN  = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [KEY_W-1:0]  key;
        logic [USER_W-1:0] user;
    } cell_cmd_t;

endpackage

/* rtl/bshl_cell.sv */
// ----------------------------------------------------------------------------
// Bounded sorted hit list cell
// One list slot: holds a key and a user index, shifts back on insert and
// toward the head on rotate.
// ----------------------------------------------------------------------------
module bshl_cell #(
    parameter int unsigned CNT_W = 5,
    parameter int unsigned INDEX = 0
) (
    input  logic                         clk,
    input  bshl_pkg::cell_cmd_t          cmd,
    input  logic [CNT_W-1:0]             count,
    input  logic                         prev_take,
    input  logic [bshl_pkg::KEY_W-1:0]   prev_key,
    input  logic [bshl_pkg::USER_W-1:0]  prev_user,
    input  logic [bshl_pkg::KEY_W-1:0]   next_key,
    input  logic [bshl_pkg::USER_W-1:0]  next_user,
    input  logic [bshl_pkg::KEY_W-1:0]   head_key,
    input  logic [bshl_pkg::USER_W-1:0]  head_user,
    output logic                         take,
    output logic [bshl_pkg::KEY_W-1:0]   key,
    output logic [bshl_pkg::USER_W-1:0]  user
);

    localparam logic [CNT_W-1:0] SLOT     = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(INDEX + 1);

    logic [bshl_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [bshl_pkg::USER_W-1:0] user_reg, user_next;
    logic                        occupied;

    assign occupied = count > SLOT;
    assign take     = !occupied || (key_reg > cmd.key);
    assign key      = key_reg;
    assign user     = user_reg;

    always_comb
    begin
        key_next  = key_reg;
        user_next = user_reg;
        unique case (cmd.op)
            bshl_pkg::CELL_INSERT:
            begin
                if (take)
                begin
                    if (prev_take)
                    begin
                        key_next  = prev_key;
                        user_next = prev_user;
                    end
                    else
                    begin
                        key_next  = cmd.key;
                        user_next = cmd.user;
                    end
                end
            end
            bshl_pkg::CELL_ROTATE:
            begin
                if (count == SLOT_END)
                begin
                    key_next  = head_key;
                    user_next = head_user;
                end
                else
                begin
                    key_next  = next_key;
                    user_next = next_user;
                end
            end
            default:
            begin
                key_next  = key_reg;
                user_next = user_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        user_reg <= user_next;
    end

endmodule

/* rtl/bounded_sorted_hit_list_core.sv */
// ----------------------------------------------------------------------------
// Bounded sorted hit list core
// Clear and insert each give one status transaction, registered and valid
// in the cycle after acceptance. Drain gives held_count transactions, one
// per cycle while the receiver is ready, as the cell chain rotates its
// occupied cells past the head; an empty list gives one status transaction.
// No new input is taken until the last one is loaded. Reset empties the
// list and clears the truncated flag; cell contents are not reset.
// ----------------------------------------------------------------------------
module bounded_sorted_hit_list_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // time_ratio[16:0], user_index[32:17], zero
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // entry_user, entry_ratio, hit_count, truncated
    output logic [0:0]  m_tuser,   // entry_valid
    output logic        m_tlast
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    bshl_pkg::state_t                state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                left_reg, left_next;
    logic                            trunc_reg, trunc_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            out_entry_reg, out_entry_next;
    logic [bshl_pkg::USER_W-1:0]     out_user_reg, out_user_next;
    logic [bshl_pkg::KEY_W-1:0]      out_ratio_reg, out_ratio_next;
    logic [CNT_W-1:0]                out_count_reg, out_count_next;
    logic                            out_trunc_reg, out_trunc_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            in_fire;
    bshl_pkg::mode_t                 mode;
    bshl_pkg::cell_cmd_t             cmd;

    logic [bshl_pkg::KEY_W-1:0]      cell_key  [CAPACITY];
    logic [bshl_pkg::USER_W-1:0]     cell_user [CAPACITY];
    logic                            cell_take [CAPACITY];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == bshl_pkg::ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign mode     = bshl_pkg::mode_t'(s_tuser);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                        p_take;
            logic [bshl_pkg::KEY_W-1:0]  p_key, n_key;
            logic [bshl_pkg::USER_W-1:0] p_user, n_user;

            if (gi == 0)
            begin : g_head
                assign p_take = 1'b0;
                assign p_key  = '0;
                assign p_user = '0;
            end
            else
            begin : g_body
                assign p_take = cell_take[gi-1];
                assign p_key  = cell_key[gi-1];
                assign p_user = cell_user[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign n_key  = cell_key[0];
                assign n_user = cell_user[0];
            end
            else
            begin : g_link
                assign n_key  = cell_key[gi+1];
                assign n_user = cell_user[gi+1];
            end

            bshl_cell #(
                .CNT_W (CNT_W),
                .INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .prev_take (p_take),
                .prev_key  (p_key),
                .prev_user (p_user),
                .next_key  (n_key),
                .next_user (n_user),
                .head_key  (cell_key[0]),
                .head_user (cell_user[0]),
                .take      (cell_take[gi]),
                .key       (cell_key[gi]),
                .user      (cell_user[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bshl_pkg::ST_IDLE:
            begin
                if (in_fire && (mode == bshl_pkg::MODE_DRAIN) && (count_reg > ONE_CNT))
                    state_next = bshl_pkg::ST_DRAIN;
            end
            bshl_pkg::ST_DRAIN:
            begin
                if (out_free && (left_reg == ONE_CNT))
                    state_next = bshl_pkg::ST_IDLE;
            end
            default: state_next = bshl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        trunc_next     = trunc_reg;
        left_next      = left_reg;
        cmd.op         = bshl_pkg::CELL_HOLD;
        cmd.key        = s_tdata[16:0];
        cmd.user       = s_tdata[32:17];
        m_tvalid_next  = out_free ? 1'b0 : m_tvalid_reg;
        out_entry_next = out_entry_reg;
        out_user_next  = out_user_reg;
        out_ratio_next = out_ratio_reg;
        out_count_next = out_count_reg;
        out_trunc_next = out_trunc_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            bshl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (mode)
                        bshl_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                            trunc_next = 1'b0;
                        end
                        bshl_pkg::MODE_INSERT:
                        begin
                            cmd.op = bshl_pkg::CELL_INSERT;
                            if (count_reg < CAP_CNT)
                                count_next = count_reg + ONE_CNT;
                            else
                                trunc_next = 1'b1;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase

                    m_tvalid_next  = 1'b1;
                    out_count_next = count_next;
                    out_trunc_next = trunc_next;
                    if ((mode == bshl_pkg::MODE_DRAIN) && (count_reg != '0))
                    begin
                        cmd.op         = bshl_pkg::CELL_ROTATE;
                        left_next      = count_reg - ONE_CNT;
                        out_entry_next = 1'b1;
                        out_user_next  = cell_user[0];
                        out_ratio_next = cell_key[0];
                        out_last_next  = (count_reg == ONE_CNT);
                    end
                    else
                    begin
                        out_entry_next = 1'b0;
                        out_user_next  = '0;
                        out_ratio_next = '0;
                        out_last_next  = 1'b1;
                    end
                end
            end
            bshl_pkg::ST_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.op         = bshl_pkg::CELL_ROTATE;
                    left_next      = left_reg - ONE_CNT;
                    m_tvalid_next  = 1'b1;
                    out_entry_next = 1'b1;
                    out_user_next  = cell_user[0];
                    out_ratio_next = cell_key[0];
                    out_count_next = count_reg;
                    out_trunc_next = trunc_reg;
                    out_last_next  = (left_reg == ONE_CNT);
                end
            end
            default:
            begin
                cmd.op = bshl_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bshl_pkg::ST_IDLE;
            count_reg    <= '0;
            left_reg     <= '0;
            trunc_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            left_reg     <= left_next;
            trunc_reg    <= trunc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg <= out_entry_next;
        out_user_reg  <= out_user_next;
        out_ratio_reg <= out_ratio_next;
        out_count_reg <= out_count_next;
        out_trunc_reg <= out_trunc_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_entry_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_trunc_reg,
                       bshl_pkg::CNT_OUT_W'(out_count_reg),
                       out_ratio_reg, out_user_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("held count above capacity");

    a_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bshl_pkg::ST_DRAIN) |-> (left_reg != '0))
        else $error("drain state with nothing left");

    a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bshl_pkg::ST_DRAIN) |-> !s_tready)
        else $error("input taken during drain");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode == bshl_pkg::MODE_CLEAR)) |=> ((count_reg == '0) && !trunc_reg))
        else $error("clear left entries behind");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bshl_pkg::ST_DRAIN && out_free && left_reg == ONE_CNT)
        |=> (m_tlast && state_reg == bshl_pkg::ST_IDLE))
        else $error("drain end without last");
`endif

endmodule

/* tb/sv/tb_bounded_sorted_hit_list_core.sv */
// ----------------------------------------------------------------------------
// Bounded sorted hit list core testbench
// Sends clear, insert, drain and unused-mode transactions over the input
// stream and checks every output transaction against a local model of the
// sorted list: ordering, ties kept in arrival order, eviction and drop when
// full, and the truncated flag. A short directed table opens the run. Random
// clear/insert/drain sequences follow under three idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_hit_list_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP         = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DIR_ROWS    = 17;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [bshl_pkg::KEY_W-1:0]  ratio;
        logic [bshl_pkg::USER_W-1:0] user;
    } hit_item_t;

    typedef struct packed {
        logic                           valid;
        logic [bshl_pkg::USER_W-1:0]    user;
        logic [bshl_pkg::KEY_W-1:0]     ratio;
        logic [bshl_pkg::CNT_OUT_W-1:0] count;
        logic                           trunc;
        logic                           last;
    } hit_result_t;

    typedef struct packed {
        logic [1:0]                     mode;
        logic [bshl_pkg::KEY_W-1:0]     ratio;
        logic [bshl_pkg::USER_W-1:0]    user;
        logic [4:0]                     reps;
        logic                           typed;
        logic [bshl_pkg::CNT_OUT_W-1:0] exp_count;
        logic                           exp_trunc;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // time_ratio[16:0], user_index[32:17], zero
    logic [1:0]  s_tuser = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // entry_user, entry_ratio, hit_count, truncated
    logic [0:0]  m_tuser;        // entry_valid
    logic        m_tlast;

    logic [bshl_pkg::KEY_W-1:0]     list_keys  [CAP];
    logic [bshl_pkg::USER_W-1:0]    list_users [CAP];
    logic [bshl_pkg::CNT_OUT_W-1:0] list_held = '0;
    logic                           list_overflow = 1'b0;

    hit_result_t expected_hits [$];
    dir_row_t    dir_table [DIR_ROWS];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned full_inserts = 0;

    bounded_sorted_hit_list_core #(
        .CAPACITY(CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    function automatic hit_result_t status_result(
        input logic [bshl_pkg::CNT_OUT_W-1:0] count,
        input logic                           trunc);
        hit_result_t r;
        r = '0;
        r.count = count;
        r.trunc = trunc;
        r.last  = 1'b1;
        return r;
    endfunction

    function automatic void predict_hit_list(input hit_item_t it);
        int unsigned pos;
        hit_result_t r;
        if (it.mode == bshl_pkg::MODE_CLEAR)
        begin
            list_held = '0;
            list_overflow = 1'b0;
        end
        else if (it.mode == bshl_pkg::MODE_INSERT)
        begin
            if (list_held == CAP)
            begin
                full_inserts++;
                list_overflow = 1'b1;
            end
            if (list_held < CAP || it.ratio < list_keys[CAP-1])
            begin
                pos = (list_held < CAP) ? list_held : CAP - 1;
                while (pos > 0 && list_keys[pos-1] > it.ratio)
                begin
                    list_keys[pos]  = list_keys[pos-1];
                    list_users[pos] = list_users[pos-1];
                    pos--;
                end
                list_keys[pos]  = it.ratio;
                list_users[pos] = it.user;
                if (list_held < CAP)
                    list_held++;
            end
        end
        if (it.mode == bshl_pkg::MODE_DRAIN && list_held != 0)
        begin
            for (int i = 0; i < list_held; i++)
            begin
                r = status_result(list_held, list_overflow);
                r.valid = 1'b1;
                r.user  = list_users[i];
                r.ratio = list_keys[i];
                r.last  = (i + 1 == list_held);
                expected_hits.push_back(r);
            end
        end
        else
        begin
            expected_hits.push_back(status_result(list_held, list_overflow));
        end
    endfunction

    // Keep the model in step; a typed row replaces the predicted status.
    task automatic send_hit_item(input hit_item_t it, input logic typed,
                                 input hit_result_t typed_exp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.user, it.ratio};
        s_tuser  <= it.mode;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        predict_hit_list(it);
        if (typed)
        begin
            void'(expected_hits.pop_back());
            expected_hits.push_back(typed_exp);
        end
    endtask

    task automatic wait_list_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_hits.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [bshl_pkg::KEY_W-1:0] pick_ratio();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return bshl_pkg::KEY_W'($urandom_range(7) * 4096);
        else if (sel < 8)
            return bshl_pkg::KEY_W'($urandom_range(65536));
        else if (sel == 8)
            return $urandom_range(1) ? bshl_pkg::KEY_W'(65536) : '0;
        else
            return bshl_pkg::KEY_W'($urandom_range(131071));
    endfunction

    function automatic hit_item_t make_item(input logic [1:0] mode);
        hit_item_t it;
        it.mode  = mode;
        it.ratio = pick_ratio();
        it.user  = bshl_pkg::USER_W'($urandom_range(65535));
        return it;
    endfunction

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned n_ins;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_hit_item(make_item(2'($urandom_range(3))), 1'b0, '0);
                sent++;
            end
            else
            begin
                send_hit_item(make_item(bshl_pkg::MODE_CLEAR), 1'b0, '0);
                n_ins = $urandom_range(24);
                for (int i = 0; i < n_ins; i++)
                begin
                    send_hit_item(make_item(bshl_pkg::MODE_INSERT), 1'b0, '0);
                    if ($urandom_range(99) < 10)
                    begin
                        send_hit_item(make_item(bshl_pkg::MODE_DRAIN), 1'b0, '0);
                        sent++;
                    end
                end
                send_hit_item(make_item(bshl_pkg::MODE_DRAIN), 1'b0, '0);
                sent += n_ins + 2;
            end
        end
        wait_list_idle();
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        hit_result_t got;
        hit_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid = m_tuser[0];
            got.user  = m_tdata[15:0];
            got.ratio = m_tdata[32:16];
            got.count = m_tdata[37:33];
            got.trunc = m_tdata[38];
            got.last  = m_tlast;
            results_checked++;
            if (expected_hits.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected transaction: valid=%0d user=%h ratio=%h count=%0d",
                             got.valid, got.user, got.ratio, got.count);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (got != want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp v=%0d u=%h r=%h n=%0d t=%0d l=%0d",
                                 want.valid, want.user, want.ratio, want.count,
                                 want.trunc, want.last);
                        $display("          got v=%0d u=%h r=%h n=%0d t=%0d l=%0d",
                                 got.valid, got.user, got.ratio, got.count,
                                 got.trunc, got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[bounded_sorted_hit_list_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        hit_item_t it;
        dir_table[0]  = '{bshl_pkg::MODE_DRAIN,  17'h00000, 16'h0000,  1, 1'b1,  0, 1'b0};
        dir_table[1]  = '{bshl_pkg::MODE_INSERT, 17'h00000, 16'h0000,  1, 1'b1,  1, 1'b0};
        dir_table[2]  = '{bshl_pkg::MODE_INSERT, 17'h10000, 16'hFFFF,  1, 1'b1,  2, 1'b0};
        dir_table[3]  = '{bshl_pkg::MODE_INSERT, 17'h1FFFF, 16'hAAAA,  1, 1'b1,  3, 1'b0};
        dir_table[4]  = '{MODE_UNUSED,           17'h15555, 16'h5555,  1, 1'b1,  3, 1'b0};
        dir_table[5]  = '{bshl_pkg::MODE_DRAIN,  17'h00000, 16'h0000,  1, 1'b0,  0, 1'b0};
        dir_table[6]  = '{bshl_pkg::MODE_INSERT, 17'h08000, 16'h0100, 13, 1'b0,  0, 1'b0};
        dir_table[7]  = '{bshl_pkg::MODE_INSERT, 17'h08000, 16'h0200,  1, 1'b1, 16, 1'b1};
        dir_table[8]  = '{bshl_pkg::MODE_INSERT, 17'h10000, 16'h0300,  1, 1'b1, 16, 1'b1};
        dir_table[9]  = '{bshl_pkg::MODE_INSERT, 17'h1FFFF, 16'hFFFF,  1, 1'b1, 16, 1'b1};
        dir_table[10] = '{bshl_pkg::MODE_INSERT, 17'h00001, 16'h0400,  1, 1'b1, 16, 1'b1};
        dir_table[11] = '{bshl_pkg::MODE_DRAIN,  17'h00000, 16'h0000,  1, 1'b0,  0, 1'b0};
        dir_table[12] = '{bshl_pkg::MODE_CLEAR,  17'h1FFFF, 16'hFFFF,  1, 1'b1,  0, 1'b0};
        dir_table[13] = '{MODE_UNUSED,           17'h00000, 16'h0000,  1, 1'b1,  0, 1'b0};
        dir_table[14] = '{bshl_pkg::MODE_DRAIN,  17'h0AAAA, 16'h5555,  1, 1'b1,  0, 1'b0};
        dir_table[15] = '{bshl_pkg::MODE_INSERT, 17'h0AAAA, 16'h5555,  1, 1'b1,  1, 1'b0};
        dir_table[16] = '{bshl_pkg::MODE_DRAIN,  17'h00000, 16'h0000,  1, 1'b0,  0, 1'b0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 87;
        foreach (dir_table[row])
        begin
            for (int k = 0; k < dir_table[row].reps; k++)
            begin
                it.mode  = dir_table[row].mode;
                it.ratio = dir_table[row].ratio;
                it.user  = dir_table[row].user + bshl_pkg::USER_W'(k);
                send_hit_item(it, dir_table[row].typed,
                              status_result(dir_table[row].exp_count,
                                            dir_table[row].exp_trunc));
            end
        end
        wait_list_idle();

        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 87;
        recv_idle_pct = 11;
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);

        repeat (10) @(posedge clk);
        $display("sent %0d transactions, checked %0d results, %0d inserts into a full list",
                 items_sent, results_checked, full_inserts);
        $display("mismatches: %0d, results still outstanding: %0d",
                 mismatch_count, expected_hits.size());
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("[bounded_sorted_hit_list_core] OK");
        else
            $display("[bounded_sorted_hit_list_core] ERROR");
        $finish;
    end

endmodule
